### rtl/atilt_pkg.sv
// Shared types, constants and the arctangent table for the tilt angle core.
// No dependencies; used by atilt_cordic and accel_tilt_angle_core.
`timescale 1ns / 1ps

package atilt_pkg;

  // Datapath widths
  localparam int SAMPLE_W    = 16;
  localparam int PRESCALE_SH = 14;
  localparam int DATA_W      = 34;   // holds the prescaled vector plus CORDIC gain
  localparam int ANGLE_W     = 32;   // binary angle, 2^32 is one full turn
  localparam int HUND_W      = 16;
  localparam int TABLE_LEN   = 24;
  localparam int IDX_W       = 5;

  localparam logic [ANGLE_W-1:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [HUND_W-1:0]  FULL_TURN     = 16'd36000;
  localparam logic [HUND_W-1:0]  OFFSET_RESET  = 16'd18000;
  localparam int                 PROD_W        = ANGLE_W + HUND_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] axis_x;
    logic signed [SAMPLE_W-1:0] axis_y;
  } in_t;

  typedef struct packed {
    logic [HUND_W-1:0] tilt_angle;
    logic              zero_vector;
  } out_t;

  // Per-stage control carried down the pipeline
  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  // atan(2^-i) in binary angle units, rounded to nearest
  function automatic logic [ANGLE_W-1:0] atan_bam(input logic [IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/atilt_cordic.sv
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
// Depends on atilt_pkg for widths, control struct and the arctangent table.
`timescale 1ns / 1ps

module atilt_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  atilt_pkg::in_t                     in_data,
  output atilt_pkg::ctl_t                    out_ctl,
  output logic [atilt_pkg::ANGLE_W-1:0]      out_angle
);

  localparam int N = (ITERATIONS > atilt_pkg::TABLE_LEN) ? atilt_pkg::TABLE_LEN : ITERATIONS;
  localparam int W = atilt_pkg::DATA_W;

  logic signed [W-1:0]                  x_q [0:N];
  logic signed [W-1:0]                  y_q [0:N];
  logic [atilt_pkg::ANGLE_W-1:0]        z_q [0:N];
  atilt_pkg::ctl_t                      ctl_q [0:N];

  logic signed [W-1:0] x_pre;
  logic signed [W-1:0] y_pre;

  // Prescale by 2^14 and sign-extend to the datapath width
  assign x_pre = {{(W-atilt_pkg::SAMPLE_W-atilt_pkg::PRESCALE_SH){in_data.axis_x[atilt_pkg::SAMPLE_W-1]}},
                  in_data.axis_x, {atilt_pkg::PRESCALE_SH{1'b0}}};
  assign y_pre = {{(W-atilt_pkg::SAMPLE_W-atilt_pkg::PRESCALE_SH){in_data.axis_y[atilt_pkg::SAMPLE_W-1]}},
                  in_data.axis_y, {atilt_pkg::PRESCALE_SH{1'b0}}};

  // Entry stage: turn left-half-plane vectors by half a turn
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else if (en) begin
      ctl_q[0].vld  <= in_vld;
      ctl_q[0].zero <= (in_data.axis_x == '0) && (in_data.axis_y == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_pre < 0) begin
        x_q[0] <= -x_pre;
        y_q[0] <= -y_pre;
        z_q[0] <= atilt_pkg::HALF_TURN;
      end else begin
        x_q[0] <= x_pre;
        y_q[0] <= y_pre;
        z_q[0] <= '0;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_iter
      logic signed [W-1:0]           dx;
      logic signed [W-1:0]           dy;
      logic [atilt_pkg::ANGLE_W-1:0] da;

      assign dx = y_q[i] >>> i;
      assign dy = x_q[i] >>> i;
      assign da = atilt_pkg::atan_bam(atilt_pkg::IDX_W'(i));

      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_q[i+1] <= '0;
        end else if (en) begin
          ctl_q[i+1] <= ctl_q[i];
        end
      end

      // Rotate towards the x axis; y sign picks the direction
      always_ff @(posedge clk) begin
        if (en) begin
          if (y_q[i] >= 0) begin
            x_q[i+1] <= x_q[i] + dx;
            y_q[i+1] <= y_q[i] - dy;
            z_q[i+1] <= z_q[i] + da;
          end else begin
            x_q[i+1] <= x_q[i] - dx;
            y_q[i+1] <= y_q[i] + dy;
            z_q[i+1] <= z_q[i] - da;
          end
        end
      end
    end
  endgenerate

  assign out_ctl   = ctl_q[N];
  assign out_angle = z_q[N];

  // The last stage only ever forwards what the entry stage saw
  a_zero_follows: assert property (@(posedge clk) disable iff (rst)
    (en && in_vld && in_data.axis_x == '0 && in_data.axis_y == '0) |=> ctl_q[0].zero)
    else $error("zero flag lost at entry stage");

  a_vld_held: assert property (@(posedge clk) disable iff (rst)
    (!en && !$past(rst)) |=> $stable(ctl_q[N]))
    else $error("pipeline moved while stalled");

  a_entry_turn: assert property (@(posedge clk) disable iff (rst)
    (en && in_vld && in_data.axis_x[atilt_pkg::SAMPLE_W-1]) |=> (z_q[0] == atilt_pkg::HALF_TURN))
    else $error("left half-plane vector not turned");

endmodule

### rtl/accel_tilt_angle_core.sv
// Tilt angle core: atan2 of an accelerometer sample pair, less a mounting offset.
// Depends on atilt_pkg and atilt_cordic.
`timescale 1ns / 1ps

//  channel   | signals                                 | beat
//  ----------+-----------------------------------------+------------------------------
//  sample    | sample_valid, sample_ready, sample      | axis_x, axis_y (signed 16 bit)
//  angle     | angle_valid, angle_ready, angle         | tilt_angle, zero_vector
//  cfg       | cfg_wr_en, cfg_wr_data                  | mount_offset, no wait
//
// One beat is taken every cycle while the skid register is empty; the stages are the entry turn,
// one stage per CORDIC micro-rotation, scale multiply, rounding, offset and output.
// The CORDIC stage chain sets the latency; the 32x16 scale multiply has its own stage.
// rst is synchronous and clears all valid bits; the offset returns to 180 degrees.
// A stalled output parks one beat in a skid register; the pipeline halts only once it is full.

module accel_tilt_angle_core #(
  parameter int ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  atilt_pkg::in_t                 sample,
  output logic                           angle_valid,
  input  logic                           angle_ready,
  output atilt_pkg::out_t                angle,
  input  logic                           cfg_wr_en,
  input  logic [atilt_pkg::HUND_W-1:0]   cfg_wr_data
);

  logic                              en;
  logic [atilt_pkg::HUND_W-1:0]      mount_offset;
  atilt_pkg::ctl_t                   cor_ctl;
  logic [atilt_pkg::ANGLE_W-1:0]     cor_angle;

  atilt_pkg::ctl_t                   mul_ctl;
  logic [atilt_pkg::PROD_W-1:0]      prod;
  atilt_pkg::ctl_t                   rnd_ctl;
  logic [atilt_pkg::HUND_W-1:0]      hund;
  atilt_pkg::ctl_t                   fin_ctl;
  logic [atilt_pkg::HUND_W-1:0]      fin_angle;

  logic [atilt_pkg::PROD_W-1:0]      prod_rnd;
  logic [atilt_pkg::HUND_W-1:0]      hund_next;
  logic [atilt_pkg::HUND_W:0]        sum;
  logic [atilt_pkg::HUND_W-1:0]      fin_next;

  logic                              skid_v;
  atilt_pkg::out_t                   skid;
  atilt_pkg::out_t                   res;

  assign en           = !skid_v;
  assign sample_ready = en;

  // Offset register, held reduced below a full turn
  always_ff @(posedge clk) begin
    if (rst) begin
      mount_offset <= atilt_pkg::OFFSET_RESET;
    end else if (cfg_wr_en) begin
      mount_offset <= (cfg_wr_data >= atilt_pkg::FULL_TURN) ?
                      cfg_wr_data - atilt_pkg::FULL_TURN : cfg_wr_data;
    end
  end

  atilt_cordic #(
    .ITERATIONS (ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (sample_valid),
    .in_data   (sample),
    .out_ctl   (cor_ctl),
    .out_angle (cor_angle)
  );

  // Binary angle to hundredths: round half up, wrap a full turn to zero
  assign prod_rnd  = prod + atilt_pkg::PROD_W'(atilt_pkg::HALF_TURN);
  assign hund_next = (prod_rnd[atilt_pkg::PROD_W-1:atilt_pkg::ANGLE_W] == atilt_pkg::FULL_TURN) ?
                     '0 : prod_rnd[atilt_pkg::PROD_W-1:atilt_pkg::ANGLE_W];

  assign sum      = {1'b0, hund} + {1'b0, atilt_pkg::FULL_TURN} - {1'b0, mount_offset};
  assign fin_next = (sum >= {1'b0, atilt_pkg::FULL_TURN}) ?
                    atilt_pkg::HUND_W'(sum - {1'b0, atilt_pkg::FULL_TURN}) :
                    atilt_pkg::HUND_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_ctl <= '0;
      rnd_ctl <= '0;
      fin_ctl <= '0;
    end else if (en) begin
      mul_ctl <= cor_ctl;
      rnd_ctl <= mul_ctl;
      fin_ctl <= rnd_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= cor_angle * atilt_pkg::PROD_W'(atilt_pkg::FULL_TURN);
      hund      <= hund_next;
      fin_angle <= rnd_ctl.zero ? '0 : fin_next;
    end
  end

  assign res.tilt_angle  = fin_angle;
  assign res.zero_vector = fin_ctl.zero;

  // Output register with one-beat skid
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
      skid_v      <= 1'b0;
    end else if (skid_v) begin
      if (angle_ready) begin
        skid_v <= 1'b0;
      end
    end else if (fin_ctl.vld) begin
      if (angle_valid && !angle_ready) begin
        skid_v <= 1'b1;
      end else begin
        angle_valid <= 1'b1;
      end
    end else if (angle_ready) begin
      angle_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (angle_ready) begin
        angle <= skid;
      end
    end else if (fin_ctl.vld) begin
      if (angle_valid && !angle_ready) begin
        skid <= res;
      end else begin
        angle <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> angle_valid)
    else $error("skid holds a beat while output is empty");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (angle.tilt_angle < atilt_pkg::FULL_TURN))
    else $error("tilt angle not wrapped");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && angle.zero_vector) |-> (angle.tilt_angle == '0))
    else $error("zero vector with non-zero angle");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    mount_offset < atilt_pkg::FULL_TURN)
    else $error("offset not reduced");

endmodule

### bench/tb_accel_tilt_angle_core.sv
// Self-checking bench for accel_tilt_angle_core: directed and random sample pairs.
// Predicts each angle beat with a CORDIC of its own; depends on atilt_pkg and the core.
`timescale 1ns / 1ps

module tb_accel_tilt_angle_core;

  localparam int HALF_PERIOD  = 10;
  localparam int ROT_STEPS    = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 204;
  localparam int NUM_PHASES   = 7;
  localparam int MAX_REPORTS  = 10;

  // atan(2^-i) as a fraction of a full turn scaled by 2^32
  localparam logic [31:0] ATAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [15:0] CORNER_VAL [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

  // offset per random phase; the sixth is drawn at random
  localparam logic [15:0] PHASE_OFFSET [NUM_PHASES] = '{
    16'd0, 16'd35999, 16'd36000, 16'd65535, 16'd9000, 16'd0, 16'd18000
  };

  typedef struct packed {
    logic [15:0]      x;
    logic [15:0]      y;
    logic             known;
    atilt_pkg::out_t  want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, '{16'd0, 1'b1}},  // zero vector: no offset, flag set
    '{16'h7FFF, 16'h0000, 1'b0, '{16'd0, 1'b0}},
    '{16'h8000, 16'h0000, 1'b0, '{16'd0, 1'b0}},
    '{16'h0000, 16'h7FFF, 1'b0, '{16'd0, 1'b0}},
    '{16'h0000, 16'h8000, 1'b0, '{16'd0, 1'b0}},
    '{16'h7FFF, 16'h7FFF, 1'b0, '{16'd0, 1'b0}},
    '{16'h8000, 16'h8000, 1'b0, '{16'd0, 1'b0}},
    '{16'h8000, 16'h7FFF, 1'b0, '{16'd0, 1'b0}},
    '{16'h7FFF, 16'h8000, 1'b0, '{16'd0, 1'b0}},
    '{16'h0001, 16'h0000, 1'b0, '{16'd0, 1'b0}},
    '{16'hFFFF, 16'h0000, 1'b0, '{16'd0, 1'b0}},
    '{16'h0000, 16'h0001, 1'b0, '{16'd0, 1'b0}},
    '{16'h0000, 16'hFFFF, 1'b0, '{16'd0, 1'b0}},
    '{16'h0001, 16'h0001, 1'b0, '{16'd0, 1'b0}},
    '{16'hFFFF, 16'hFFFF, 1'b0, '{16'd0, 1'b0}},
    '{16'hFFFF, 16'h0001, 1'b0, '{16'd0, 1'b0}},
    '{16'h0001, 16'hFFFF, 1'b0, '{16'd0, 1'b0}},
    '{16'h8000, 16'hFFFF, 1'b0, '{16'd0, 1'b0}},  // just past the half turn
    '{16'h8000, 16'h0001, 1'b0, '{16'd0, 1'b0}},
    '{16'h7FFF, 16'hFFFF, 1'b0, '{16'd0, 1'b0}},  // rounds up to a full turn
    '{16'hAAAA, 16'h5555, 1'b0, '{16'd0, 1'b0}},
    '{16'h5555, 16'hAAAA, 1'b0, '{16'd0, 1'b0}}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  atilt_pkg::in_t   sample = '0;
  logic             angle_valid;
  logic             angle_ready = 1'b0;
  atilt_pkg::out_t  angle;
  logic             cfg_wr_en = 1'b0;
  logic [15:0]      cfg_wr_data = '0;

  atilt_pkg::out_t  pending_tilt [$];
  logic [15:0]      mount_off = atilt_pkg::OFFSET_RESET;
  int               send_idle = 0;
  int               recv_idle = 0;
  int               fail_count = 0;
  int               quiet_cycles = 0;
  int               stall_left = 0;
  logic             stall_req = 1'b0;

  accel_tilt_angle_core #(
    .ITERATIONS(ROT_STEPS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .angle       (angle),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic atilt_pkg::out_t tilt_of(atilt_pkg::in_t s, logic [15:0] offset);
    longint           vx, vy, dx, dy;
    logic [31:0]      z;
    logic [63:0]      prod;
    int unsigned      hund, off;
    atilt_pkg::out_t  r;
    r = '0;
    if (s.axis_x == 16'sd0 && s.axis_y == 16'sd0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    vx = longint'($signed(s.axis_x)) * 16384;
    vy = longint'($signed(s.axis_y)) * 16384;
    z  = '0;
    // turn the left half plane through 180 degrees first
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      z  = atilt_pkg::HALF_TURN;
    end
    for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        z  = z + ATAN_STEP[i];
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        z  = z - ATAN_STEP[i];
      end
    end
    prod = {32'd0, z} * 64'd36000 + 64'h8000_0000;
    hund = prod[63:32] % 36000;
    off  = offset % 36000;
    hund = (hund + 36000 - off) % 36000;
    r.tilt_angle = hund[15:0];
    return r;
  endfunction

  function automatic atilt_pkg::in_t random_sample();
    atilt_pkg::in_t s;
    int             a, b;
    s = '0;
    case ($urandom_range(9))
      0: begin
        // zero vector or a pure axis
        if ($urandom_range(1) == 0) s = '0;
        else if ($urandom_range(1) == 0) s.axis_x = 16'($urandom());
        else s.axis_y = 16'($urandom());
      end
      1, 2: begin
        a = int'($urandom_range(16)) - 8;
        b = int'($urandom_range(16)) - 8;
        s.axis_x = a[15:0];
        s.axis_y = b[15:0];
      end
      3: begin
        s.axis_x = CORNER_VAL[$urandom_range(4)];
        s.axis_y = CORNER_VAL[$urandom_range(4)];
      end
      4: begin
        a = int'($urandom_range(6)) - 3;
        if ($urandom_range(1) == 0) begin
          s.axis_x = 16'($urandom());
          s.axis_y = a[15:0];
        end else begin
          s.axis_x = a[15:0];
          s.axis_y = 16'($urandom());
        end
      end
      default: begin
        s.axis_x = 16'($urandom());
        s.axis_y = 16'($urandom());
      end
    endcase
    return s;
  endfunction

  task automatic send_sample(atilt_pkg::in_t s, atilt_pkg::out_t want);
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    pending_tilt.push_back(want);
  endtask

  // drop valid and hold until every outstanding angle has come back
  task automatic drain_angles();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_tilt.size() != 0);
  endtask

  task automatic write_offset(logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mount_off    = v;
  endtask

  // receiver: random back-pressure, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      angle_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      angle_ready <= 1'b0;
    end else if (stall_req) begin
      stall_req   <= 1'b0;
      stall_left  <= HOLD_CYCLES;
      angle_ready <= 1'b0;
    end else begin
      angle_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    atilt_pkg::out_t want;
    if (!rst && angle_valid && angle_ready) begin
      if (pending_tilt.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected angle beat: tilt_angle=%0d zero_vector=%0b",
                   angle.tilt_angle, angle.zero_vector);
      end else begin
        want = pending_tilt.pop_front();
        if (angle.tilt_angle !== want.tilt_angle || angle.zero_vector !== want.zero_vector) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("angle mismatch: expected %0d/%0b got %0d/%0b",
                     want.tilt_angle, want.zero_vector, angle.tilt_angle, angle.zero_vector);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (angle_valid && angle_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    atilt_pkg::in_t   s;
    atilt_pkg::out_t  want;
    logic [15:0]      off;
    send_idle = 21;
    recv_idle = 55;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      s.axis_x = DIRECTED[i].x;
      s.axis_y = DIRECTED[i].y;
      want = DIRECTED[i].known ? DIRECTED[i].want : tilt_of(s, mount_off);
      send_sample(s, want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_angles();
      off = (ph == 5) ? 16'($urandom_range(65535)) : PHASE_OFFSET[ph];
      write_offset(off);
      if (ph < 2) begin
        send_idle = 21;
        recv_idle = 55;
      end else if (ph < 4) begin
        send_idle = 55;
        recv_idle = 21;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // fill the pipeline against a long hold on the output
      if (ph == 0) stall_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_angles();
        s = random_sample();
        send_sample(s, tilt_of(s, mount_off));
      end
    end

    drain_angles();
    repeat (ROT_STEPS + 10) @(posedge clk);
    if (pending_tilt.size() != 0) begin
      fail_count += pending_tilt.size();
      $display("%0d angle beats never arrived", pending_tilt.size());
    end
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/atilt_pkg.sv
rtl/atilt_cordic.sv
rtl/accel_tilt_angle_core.sv
bench/tb_accel_tilt_angle_core.sv
